// ----- rtl/prle_pkg.sv -----
// ----------------------------------------------------------------------------
// prle_pkg
// Shared types and constants for the pulse to rle sample encoder.
// ----------------------------------------------------------------------------
package prle_pkg;

  // field widths fixed by the interface
  localparam int PULSE_W      = 32;
  localparam int SCALE_W      = 22;
  localparam int RUN_W        = 32;
  localparam int BYTE_W       = 8;

  // defaults and limits
  localparam int TICK_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(79);
  localparam logic [RUN_W-1:0]   SHORT_RUN_MAX = RUN_W'(8'hff);
  localparam logic [BYTE_W-1:0]  ESCAPE_BYTE = '0;

  // input transfer payload
  typedef struct packed {
    logic [PULSE_W-1:0] pulse_ticks;
    logic               no_edge;
    logic               end_of_tape;
  } prle_in_t;

  // output transfer payload
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } prle_out_t;

  // classified event held in the queue
  typedef struct packed {
    logic [PULSE_W-1:0] pulse_ticks;
    logic               has_edge;
    logic               end_of_tape;
  } prle_item_t;

  // queue head handshake toward the back end
  typedef struct packed {
    logic valid;
    logic pop;
  } prle_qctl_t;

endpackage

// ----- rtl/pulse_to_rle_sample_encoder.sv -----
// ----------------------------------------------------------------------------
// pulse_to_rle_sample_encoder
// Turns tape event durations into a run length byte stream.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      in_valid / in_stall     prle_in_t  in_data
//  out       output     out_valid / out_stall   prle_out_t out_data
//  cfg       input      cfg_wr_en               ticks_per_sample cfg_wr_data
//
//  an edge event holds the back end while the one bit per cycle divider
//  runs and then while its output bytes (none, one or five) pass through
//  the single output register, longer while out is stalled; a no-edge
//  event is taken in idle without leaving it. a two entry queue takes new
//  events while the back end works or the output is stalled.
//  rst is synchronous: it clears the balance, queue and sets the scale to 79.
// ----------------------------------------------------------------------------
module pulse_to_rle_sample_encoder
  import prle_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  prle_in_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output prle_out_t          out_data
);

  prle_item_t head;
  prle_qctl_t qctl;
  logic       head_valid;
  logic       head_pop;

  assign qctl.valid = head_valid;
  assign qctl.pop   = head_pop;

  // front end: accept and queue events
  prle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (qctl.pop)
  );

  // back end: balance, divide and emit
  prle_back #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .qctl_in     (qctl),
    .head_pop    (head_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ----- rtl/prle_front.sv -----
// ----------------------------------------------------------------------------
// prle_front
// Accepts tape events, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module prle_front
  import prle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  prle_in_t   in_data,
  output prle_item_t head,
  output logic       head_valid,
  input  logic       head_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  prle_item_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     fill;
  logic                 push;
  logic                 pop;
  prle_item_t           item_in;

  // classify the incoming event
  assign item_in.pulse_ticks = in_data.pulse_ticks;
  assign item_in.has_edge    = ~in_data.no_edge;
  assign item_in.end_of_tape = in_data.end_of_tape;

  assign in_stall   = (fill == CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid & ~in_stall;
  assign head_valid = (fill != '0);
  assign pop        = head_pop & head_valid;
  assign head       = entries[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/prle_div.sv -----
// ----------------------------------------------------------------------------
// prle_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prle_div
  import prle_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [TICK_WIDTH-1:0] dividend,
  input  logic [SCALE_W-1:0]    divisor,
  output logic                  done,
  output logic [TICK_WIDTH-1:0] quotient,
  output logic [SCALE_W-1:0]    remainder
);

  localparam int CNT_W = $clog2(TICK_WIDTH + 1);

  logic [SCALE_W-1:0]    dvs;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic [SCALE_W:0]      trial;
  logic                  fits;

  // one shift and trial subtract
  assign trial = {remainder, quotient[TICK_WIDTH-1]};
  assign fits  = (trial >= {1'b0, dvs});

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[TICK_WIDTH-2:0], fits};
      remainder <= fits ? SCALE_W'(trial - {1'b0, dvs}) : trial[SCALE_W-1:0];
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(TICK_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/prle_back.sv -----
// ----------------------------------------------------------------------------
// prle_back
// Keeps the tick balance, divides on edges and emits the run length bytes.
// ----------------------------------------------------------------------------
module prle_back
  import prle_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_wr_data,
  input  prle_item_t         head,
  input  prle_qctl_t         qctl_in,
  output logic               head_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output prle_out_t          out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state;
  logic [SCALE_W-1:0]    ticks_per_sample;
  logic [TICK_WIDTH-1:0] tick_balance;
  logic [TICK_WIDTH-1:0] balance_sum;
  logic                  eot;
  logic [RUN_W-1:0]      run;
  logic                  long_run;
  logic [2:0]            byte_idx;
  logic                  div_start;
  logic                  div_done;
  logic [TICK_WIDTH-1:0] div_quo;
  logic [SCALE_W-1:0]    div_rem;
  logic [SCALE_W-1:0]    divisor;
  logic                  out_free;
  logic [BYTE_W-1:0]     next_byte;
  logic                  next_last;

  assign balance_sum = tick_balance + head.pulse_ticks[TICK_WIDTH-1:0];
  assign divisor     = (ticks_per_sample == '0) ? SCALE_W'(1) : ticks_per_sample;
  assign head_pop    = (state == ST_IDLE) & qctl_in.valid;
  assign div_start   = head_pop & head.has_edge;
  assign out_free    = ~out_valid | ~out_stall;

  prle_div #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (balance_sum),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // byte selection for the current emit step
  always_comb begin
    next_last = 1'b1;
    next_byte = run[BYTE_W-1:0];
    if (long_run) begin
      next_last = (byte_idx == 3'd4);
      case (byte_idx)
        3'd0:    next_byte = ESCAPE_BYTE;
        3'd1:    next_byte = run[7:0];
        3'd2:    next_byte = run[15:8];
        3'd3:    next_byte = run[23:16];
        3'd4:    next_byte = run[31:24];
        default: next_byte = ESCAPE_BYTE;
      endcase
    end
  end

  // scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_sample <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      ticks_per_sample <= cfg_wr_data;
    end
  end

  // run and output payload
  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_done) begin
      run      <= RUN_W'(div_quo);
      long_run <= (RUN_W'(div_quo) > SHORT_RUN_MAX);
    end
    if (state == ST_EMIT && out_free) begin
      out_data.out_byte    <= next_byte;
      out_data.last_of_run <= next_last;
    end
  end

  // control: balance, sequencing and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tick_balance <= '0;
      eot          <= 1'b0;
      byte_idx     <= '0;
      out_valid    <= 1'b0;
    end else begin
      // hold a stalled byte, load a new one on an emit step
      out_valid <= (out_valid & out_stall) | ((state == ST_EMIT) & out_free);
      case (state)
        ST_IDLE: begin
          if (head_pop) begin
            eot <= head.end_of_tape;
            if (head.has_edge) begin
              state <= ST_DIV;
            end else begin
              tick_balance <= head.end_of_tape ? '0 : balance_sum;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            tick_balance <= eot ? '0 : TICK_WIDTH'(div_rem);
            byte_idx     <= '0;
            state        <= (div_quo == '0) ? ST_IDLE : ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            byte_idx <= byte_idx + 1'b1;
            if (next_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sim/tb_pulse_to_rle_sample_encoder.sv -----
// ----------------------------------------------------------------------------
// tb_pulse_to_rle_sample_encoder
// Self-checking bench for the pulse to rle sample encoder. A directed table
// covers reset state, run length boundaries, the zero escape, flag handling,
// wrap of the tick balance and the scale extremes. Random tape events follow
// under several scale settings and handshake mixes. Every output byte is
// compared in order against the table or a local model of the balance and divider.
// ----------------------------------------------------------------------------
module tb_pulse_to_rle_sample_encoder;
  import prle_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 9;
  // time for two queued events plus one in the back end to finish
  localparam int SETTLE_CYCLES = 150;
  localparam int STALL_LIMIT   = 2000;
  localparam int SEGMENTS      = 6;
  localparam int SEG_EVENTS    = 32;
  localparam int NUM_MIXES     = 4;
  localparam logic [SCALE_W-1:0] SCALE_TOP = SCALE_W'(3500000);
  localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

  // handshake mixes: none, sender idle, receiver stall, both
  localparam int SEND_IDLE_PCT [NUM_MIXES] = '{0, 75, 0, 17};
  localparam int RECV_STALL_PCT[NUM_MIXES] = '{0, 0, 75, 17};

  // one directed step: either a scale write or a tape event
  typedef struct packed {
    logic               is_cfg;
    logic [SCALE_W-1:0] scale;
    prle_in_t           ev;
    logic               typed;
    logic [2:0]         n_bytes;
    logic [39:0]        bytes;
  } tape_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [SCALE_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  prle_in_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  prle_out_t          out_data;

  // model state and scoreboard
  logic [PULSE_W-1:0] bal_ticks = '0;
  logic [SCALE_W-1:0] samp_scale = SCALE_RESET;
  prle_out_t          rle_bytes_due[$];
  tape_row_t          dir_rows[$];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int events_sent    = 0;
  int bytes_checked  = 0;
  int escaped_runs   = 0;
  int scales_used    = 0;
  int idle_cycles    = 0;

  pulse_to_rle_sample_encoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // add the event to the balance, divide on an edge; returns the run length
  function automatic logic [PULSE_W-1:0] fold_pulse(prle_in_t ev);
    logic [PULSE_W-1:0] div;
    logic [PULSE_W-1:0] run;
    run = '0;
    bal_ticks = bal_ticks + ev.pulse_ticks;
    if (!ev.no_edge) begin
      div = (samp_scale == '0) ? PULSE_W'(1) : PULSE_W'(samp_scale);
      run = bal_ticks / div;
      bal_ticks = bal_ticks % div;
    end
    if (ev.end_of_tape) begin
      bal_ticks = '0;
    end
    return run;
  endfunction

  // bytes for one run: short form, or escape plus little-endian dword
  function automatic void queue_run(logic [PULSE_W-1:0] run);
    if (run == '0) begin
      return;
    end
    if (run <= SHORT_RUN_MAX) begin
      rle_bytes_due.push_back('{out_byte: run[7:0], last_of_run: 1'b1});
    end else begin
      escaped_runs++;
      rle_bytes_due.push_back('{out_byte: ESCAPE_BYTE, last_of_run: 1'b0});
      for (int i = 0; i < 4; i++) begin
        rle_bytes_due.push_back('{out_byte: run[8*i +: 8], last_of_run: (i == 3)});
      end
    end
  endfunction

  function automatic tape_row_t ev_row(logic [PULSE_W-1:0] ticks, logic ne, logic eot,
                                       logic typed, logic [2:0] n, logic [39:0] b);
    tape_row_t r;
    r = '0;
    r.ev.pulse_ticks = ticks;
    r.ev.no_edge = ne;
    r.ev.end_of_tape = eot;
    r.typed = typed;
    r.n_bytes = n;
    r.bytes = b;
    return r;
  endfunction

  function automatic tape_row_t cfg_row(logic [SCALE_W-1:0] v);
    tape_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.scale = v;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // drop valid and hold until every due byte is out and the back end is quiet
  task automatic wait_drained();
    in_valid = 1'b0;
    while (rle_bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // scale write, only with the block idle
  task automatic program_scale(input logic [SCALE_W-1:0] v);
    wait_drained();
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    samp_scale = v;
    scales_used++;
  endtask

  // one input transfer; entered and left at a falling edge
  task automatic send_event(input prle_in_t ev, input logic typed, input logic [2:0] n,
                            input logic [39:0] b);
    logic [PULSE_W-1:0] run;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = ev;
    do @(posedge clk); while (in_stall !== 1'b0);
    run = fold_pulse(ev);
    if (typed) begin
      for (int i = 0; i < n; i++) begin
        rle_bytes_due.push_back('{out_byte: b[8*i +: 8], last_of_run: (i == n - 1)});
      end
    end else begin
      queue_run(run);
    end
    events_sent++;
    @(negedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // output transfer check against the oldest due byte
  always @(posedge clk) begin
    prle_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (rle_bytes_due.size() == 0) begin
        note_mismatch($sformatf("unexpected byte %02h last %0b",
                                out_data.out_byte, out_data.last_of_run));
      end else begin
        want = rle_bytes_due.pop_front();
        bytes_checked++;
        if (out_data.out_byte !== want.out_byte) begin
          note_mismatch($sformatf("out_byte %02h, want %02h",
                                  out_data.out_byte, want.out_byte));
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          note_mismatch($sformatf("last_of_run %0b, want %0b on byte %02h",
                                  out_data.last_of_run, want.last_of_run, want.out_byte));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d bytes outstanding",
                 idle_cycles, rle_bytes_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    tape_row_t          row;
    prle_in_t           ev;
    logic [PULSE_W-1:0] eff;
    logic [63:0]        prod;
    int                 pick;
    logic [SCALE_W-1:0] seg_scale[SEGMENTS];

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table; scale starts at its reset value of 79
    dir_rows.push_back(ev_row(32'd0,     1'b0, 1'b0, 1'b1, 3'd0, 40'h0));
    dir_rows.push_back(ev_row(32'd79,    1'b0, 1'b0, 1'b1, 3'd1, 40'h01));
    dir_rows.push_back(ev_row(32'd20145, 1'b0, 1'b0, 1'b1, 3'd1, 40'hff));
    dir_rows.push_back(ev_row(32'd20224, 1'b0, 1'b0, 1'b1, 3'd5, 40'h00_00_01_00_00));
    dir_rows.push_back(ev_row(32'd78,    1'b0, 1'b0, 1'b1, 3'd0, 40'h0));
    dir_rows.push_back(ev_row(32'd1,     1'b0, 1'b0, 1'b1, 3'd1, 40'h01));
    // no-edge only accumulates, end of tape clears afterwards
    dir_rows.push_back(ev_row(32'd50,    1'b1, 1'b0, 1'b1, 3'd0, 40'h0));
    dir_rows.push_back(ev_row(32'd50,    1'b0, 1'b1, 1'b1, 3'd1, 40'h01));
    dir_rows.push_back(ev_row(32'd78,    1'b0, 1'b0, 1'b1, 3'd0, 40'h0));
    dir_rows.push_back(ev_row(32'd30,    1'b1, 1'b1, 1'b1, 3'd0, 40'h0));
    dir_rows.push_back(ev_row(32'd78,    1'b0, 1'b0, 1'b1, 3'd0, 40'h0));
    dir_rows.push_back(ev_row(32'd1,     1'b0, 1'b1, 1'b1, 3'd1, 40'h01));
    // balance wrap
    dir_rows.push_back(ev_row(32'hffff_ffff, 1'b0, 1'b0, 1'b0, 3'd0, 40'h0));
    dir_rows.push_back(ev_row(32'hffff_ffff, 1'b1, 1'b0, 1'b0, 3'd0, 40'h0));
    dir_rows.push_back(ev_row(32'd31,    1'b0, 1'b1, 1'b0, 3'd0, 40'h0));
    // smallest scale and the largest run
    dir_rows.push_back(cfg_row(SCALE_W'(1)));
    dir_rows.push_back(ev_row(32'd255,   1'b0, 1'b0, 1'b1, 3'd1, 40'hff));
    dir_rows.push_back(ev_row(32'd256,   1'b0, 1'b0, 1'b1, 3'd5, 40'h00_00_01_00_00));
    dir_rows.push_back(ev_row(32'hffff_ffff, 1'b0, 1'b1, 1'b1, 3'd5, 40'hff_ff_ff_ff_00));
    // zero scale acts as one
    dir_rows.push_back(cfg_row(SCALE_W'(0)));
    dir_rows.push_back(ev_row(32'd5,     1'b0, 1'b0, 1'b1, 3'd1, 40'h05));
    dir_rows.push_back(ev_row(32'd0,     1'b0, 1'b1, 1'b1, 3'd0, 40'h0));
    // widest scale values
    dir_rows.push_back(cfg_row(SCALE_MAX));
    dir_rows.push_back(ev_row(32'hffff_ffff, 1'b0, 1'b1, 1'b0, 3'd0, 40'h0));
    dir_rows.push_back(cfg_row(SCALE_TOP));
    dir_rows.push_back(ev_row(32'd892500000,  1'b0, 1'b0, 1'b0, 3'd0, 40'h0));
    dir_rows.push_back(ev_row(32'd1050000000, 1'b0, 1'b1, 1'b0, 3'd0, 40'h0));

    send_idle_pct = SEND_IDLE_PCT[3];
    recv_stall_pct = RECV_STALL_PCT[3];
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        program_scale(row.scale);
      end else begin
        send_event(row.ev, row.typed, row.n_bytes, row.bytes);
      end
    end

    // random segments, each with its own scale and handshake mix
    seg_scale = '{SCALE_RESET, SCALE_W'(1), SCALE_TOP, SCALE_W'($urandom_range(2, 300)),
                  SCALE_MAX, SCALE_W'(0)};
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      program_scale(seg_scale[seg]);
      send_idle_pct = SEND_IDLE_PCT[seg % NUM_MIXES];
      recv_stall_pct = RECV_STALL_PCT[seg % NUM_MIXES];
      eff = (samp_scale == '0) ? PULSE_W'(1) : PULSE_W'(samp_scale);
      for (int k = 0; k < SEG_EVENTS; k++) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          prod = 64'(eff) * 64'($urandom_range(1, 255));
        end else if (pick < 55) begin
          prod = 64'(eff) * 64'($urandom_range(256, 100000));
        end else if (pick < 70) begin
          prod = 64'($urandom_range(0, eff - 1));
        end else if (pick < 85) begin
          prod = 64'($urandom());
        end else if (pick < 90) begin
          prod = '0;
        end else if (pick < 95) begin
          prod = 64'(32'hffff_ffff);
        end else begin
          prod = 64'(eff) * 64'($urandom_range(255, 256));
        end
        ev.pulse_ticks = prod[PULSE_W-1:0];
        ev.no_edge = ($urandom_range(99) < 20);
        ev.end_of_tape = ($urandom_range(99) < 8);
        send_event(ev, 1'b0, 3'd0, 40'h0);
        // now and then hold off until the output side is empty
        if ($urandom_range(24) == 0) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    $display("covered %0d tape events over %0d scale writes and %0d handshake mixes",
             events_sent, scales_used, NUM_MIXES);
    $display("checked %0d output bytes, %0d of the runs in escaped form",
             bytes_checked, escaped_runs);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
